// ===== design/sorted_unique_key_set_assert.svh =====
// Assertion macros for the sorted key set datapath.
`ifndef SORTED_UNIQUE_KEY_SET_ASSERT_SVH
`define SORTED_UNIQUE_KEY_SET_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SUKS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("suks assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SUKS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("suks assertion failed");

`endif

// ===== design/suks_pkg.sv =====
// Package: sizes, opcodes, FSM states and controller/datapath structs.
package suks_pkg;

    localparam int CAPACITY   = 16;
    localparam int KEY_WIDTH  = 8;
    localparam int KEY_PORT_W = 8;
    localparam int OUT_CNT_W  = 5;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W      = $clog2(CAPACITY);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_DUMP   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DUMP
    } t_state;

    typedef struct packed {
        logic capture;    // latch the input item
        logic exec;       // run insert/delete/search or empty dump, load result
        logic emit_dump;  // load one dumped entry into the result register
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic empty;
        logic dump_last;
    } t_status;

endpackage

// ===== design/suks_req_if.sv =====
// Request channel interface: opcode and key.
interface suks_req_if;
    import suks_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [1:0]            opcode;
    logic [KEY_PORT_W-1:0] key_in;

    modport source (output valid, output opcode, output key_in, input ready);
    modport sink   (input valid, input opcode, input key_in, output ready);
endinterface

// ===== design/suks_rsp_if.sv =====
// Response channel interface: lookup flags, dumped key, count and last.
interface suks_rsp_if;
    import suks_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic                  full_drop;
    logic                  entry_valid;
    logic [KEY_PORT_W-1:0] key_out;
    logic [OUT_CNT_W-1:0]  count;
    logic                  last;

    modport source (output valid, output hit, output full_drop, output entry_valid,
                    output key_out, output count, output last, input ready);
    modport sink   (input valid, input hit, input full_drop, input entry_valid,
                    input key_out, input count, input last, output ready);
endinterface

// ===== design/suks_ctrl.sv =====
// Controller FSM: input acceptance, execute step, dump sequencing, result valid.
module suks_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output suks_pkg::t_cmd    o_cmd,
    input  suks_pkg::t_status i_sts
);
    import suks_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_slot_free;
    logic   w_load;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_load      = o_cmd.exec || o_cmd.emit_dump;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.op == OP_DUMP && !i_sts.empty) n_state = S_DUMP;
                else if (w_slot_free) n_state = S_IDLE;
            end
            S_DUMP: begin
                if (w_slot_free && i_sts.dump_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.capture   = 1'b0;
        o_cmd.exec      = 1'b0;
        o_cmd.emit_dump = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_EXEC: begin
                // a non-empty dump goes straight to the entry loop
                o_cmd.exec = w_slot_free && !(i_sts.op == OP_DUMP && !i_sts.empty);
            end
            S_DUMP: begin
                o_cmd.emit_dump = w_slot_free;
            end
            default: ;
        endcase
    end

    always_comb begin
        if (w_load) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
        else n_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

// ===== design/suks_dpath.sv =====
// Datapath: sorted cell row with parallel compare, shift insert/delete, result register.
`include "sorted_unique_key_set_assert.svh"
module suks_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [1:0]                      i_opcode,
    input  logic [suks_pkg::KEY_PORT_W-1:0] i_key_in,
    input  suks_pkg::t_cmd                  i_cmd,
    output suks_pkg::t_status               o_sts,
    output logic                            o_hit,
    output logic                            o_full_drop,
    output logic                            o_entry_valid,
    output logic [suks_pkg::KEY_PORT_W-1:0] o_key_out,
    output logic [suks_pkg::OUT_CNT_W-1:0]  o_count,
    output logic                            o_last
);
    import suks_pkg::*;

    t_op                  r_op;
    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] r_cells [CAPACITY];
    logic [KEY_WIDTH-1:0] n_cells [CAPACITY];
    logic [CNT_W-1:0]     r_count, n_count;
    logic [IDX_W-1:0]     r_idx;

    logic [CAPACITY-1:0]  w_lt;
    logic [CAPACITY-1:0]  w_eq;
    logic [CAPACITY-1:0]  w_prev_lt;
    logic [KEY_WIDTH-1:0] w_prev_cell [CAPACITY];
    logic [KEY_WIDTH-1:0] w_next_cell [CAPACITY];
    logic                 w_found;
    logic                 w_full;
    logic                 w_do_ins;
    logic                 w_do_del;
    logic                 w_dump_last;

    // per-cell compare against the held key; cells past the count are ignored
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic w_valid;
        assign w_valid = CNT_W'(i) < r_count;
        assign w_lt[i] = w_valid && (r_cells[i] < r_key);
        assign w_eq[i] = w_valid && (r_cells[i] == r_key);
        if (i == 0) begin : g_first
            assign w_prev_lt[i]   = 1'b1;
            assign w_prev_cell[i] = r_key;
        end else begin : g_mid
            assign w_prev_lt[i]   = w_lt[i-1];
            assign w_prev_cell[i] = r_cells[i-1];
        end
        if (i == CAPACITY - 1) begin : g_tail
            assign w_next_cell[i] = r_cells[i];
        end else begin : g_body
            assign w_next_cell[i] = r_cells[i+1];
        end
    end

    assign w_found  = |w_eq;
    assign w_full   = r_count >= CNT_W'(CAPACITY);
    assign w_do_ins = (r_op == OP_INSERT) && !w_found && !w_full;
    assign w_do_del = (r_op == OP_DELETE) && w_found;

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_cells[i] = r_cells[i];
            if (w_do_ins && !w_lt[i]) begin
                n_cells[i] = w_prev_lt[i] ? r_key : w_prev_cell[i];
            end else if (w_do_del && !w_lt[i]) begin
                n_cells[i] = w_next_cell[i];
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_do_ins) n_count = r_count + CNT_W'(1);
        else if (w_do_del) n_count = r_count - CNT_W'(1);
    end

    assign w_dump_last = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= t_op'(i_opcode);
            r_key <= KEY_WIDTH'(i_key_in);
            r_idx <= '0;
        end
        if (i_cmd.exec) begin
            for (int i = 0; i < CAPACITY; i++) r_cells[i] <= n_cells[i];
            o_hit         <= (r_op != OP_DUMP) && w_found;
            o_full_drop   <= (r_op == OP_INSERT) && !w_found && w_full;
            o_entry_valid <= 1'b0;
            o_key_out     <= (r_op == OP_DUMP) ? '0 : KEY_PORT_W'(r_key);
            o_count       <= OUT_CNT_W'(n_count);
            o_last        <= 1'b1;
        end
        if (i_cmd.emit_dump) begin
            o_hit         <= 1'b0;
            o_full_drop   <= 1'b0;
            o_entry_valid <= 1'b1;
            o_key_out     <= KEY_PORT_W'(r_cells[r_idx]);
            o_count       <= OUT_CNT_W'(r_count);
            o_last        <= w_dump_last;
            r_idx         <= r_idx + IDX_W'(1);
        end
    end

    assign o_sts.op        = r_op;
    assign o_sts.empty     = r_count == '0;
    assign o_sts.dump_last = w_dump_last;

    `SUKS_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY))
    `SUKS_ASSERT_NXT(a_full_hold, i_clk, i_rst_n, i_cmd.exec && r_op == OP_INSERT && w_full,
                     $stable(r_count))
    `SUKS_ASSERT_NXT(a_del_dec, i_clk, i_rst_n, i_cmd.exec && w_do_del,
                     r_count == $past(r_count) - CNT_W'(1))
    `SUKS_ASSERT_IMP(a_dump_idx, i_clk, i_rst_n, i_cmd.emit_dump,
                     CNT_W'(r_idx) < r_count)
endmodule

// ===== design/sorted_unique_key_set.sv =====
// Top level: sorted unique key set, controller plus cell-row datapath.
//
//  channel  | dir | transfer moves
//  ---------+-----+-----------------------------------------------------
//  i_req    | in  | opcode, key_in
//  o_rsp    | out | hit, full_drop, entry_valid, key_out, count, last
//
// Insert, delete and search are accepted, then run one compare/shift pass
// over the cell row that also loads the result register.
// Dump gives one output transfer per stored key, or a single one when empty.
// In the datapath, reset clears the key count only; the cell row needs no clearing pass.
// A stalled output holds the result register and the controller; the next
// request is taken once the current item's last result is loaded.
module sorted_unique_key_set (
    input  logic i_clk,
    input  logic i_rst_n,
    suks_req_if.sink   i_req,
    suks_rsp_if.source o_rsp
);
    import suks_pkg::*;

    t_cmd    w_cmd;
    t_status w_sts;

    suks_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    suks_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_opcode      (i_req.opcode),
        .i_key_in      (i_req.key_in),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_hit         (o_rsp.hit),
        .o_full_drop   (o_rsp.full_drop),
        .o_entry_valid (o_rsp.entry_valid),
        .o_key_out     (o_rsp.key_out),
        .o_count       (o_rsp.count),
        .o_last        (o_rsp.last)
    );
endmodule
